/* rtl/antialiased_line_rasterizer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the antialiased line rasterizer
// Concurrent checks on the rising clock, quiet while reset is high.
// Define ASSERT_OFF to compile the checks away.
// ----------------------------------------------------------------------------
`ifndef ANTIALIASED_LINE_RASTERIZER_TOP_DEFINES_SVH
`define ANTIALIASED_LINE_RASTERIZER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define ALR_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define ALR_ASSERT_NEVER(lbl, expr, msg) \
   `ALR_ASSERT(lbl, !(expr), msg)
`else
`define ALR_ASSERT(lbl, prop, msg)
`define ALR_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

/* rtl/alr_pkg.sv */
// ----------------------------------------------------------------------------
// Antialiased line rasterizer package
// Field widths, parameter defaults and the control types shared by the
// top level and the pixel walker.
// ----------------------------------------------------------------------------
package alr_pkg;

   localparam int FIELD_W         = 6;
   localparam int INTEN_W         = 8;
   localparam int COORD_BITS_DEF  = 6;
   localparam int FRAC_BITS_DEF   = 15;

   localparam logic [INTEN_W-1:0] INTEN_FULL = 8'hFF;

   typedef struct packed {
      logic start;
      logic oct_err;
   } alr_walk_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } alr_walk_stat_type;

endpackage

/* rtl/alr_if.sv */
// ----------------------------------------------------------------------------
// Antialiased line rasterizer channels
// Valid/ready channels for line commands and for pixel results.
// ----------------------------------------------------------------------------
interface alr_req_if;
   import alr_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] x_start;
   logic [FIELD_W-1:0] y_start;
   logic [FIELD_W-1:0] x_end;
   logic [FIELD_W-1:0] y_end;

   modport source (output valid, output x_start, output y_start, output x_end,
                   output y_end, input ready);
   modport sink   (input valid, input x_start, input y_start, input x_end,
                   input y_end, output ready);
endinterface

interface alr_rsp_if;
   import alr_pkg::*;

   logic               valid;
   logic               ready;
   logic [FIELD_W-1:0] pixel_x;
   logic [FIELD_W-1:0] pixel_y;
   logic [INTEN_W-1:0] intensity;
   logic               last;
   logic               octant_error;

   modport source (output valid, output pixel_x, output pixel_y, output intensity,
                   output last, output octant_error, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input intensity,
                   input last, input octant_error, output ready);
endinterface

/* rtl/alr_sub_unit.sv */
// ----------------------------------------------------------------------------
// Shared compare-subtract unit
// One subtractor with its borrow used as the greater-or-equal flag; serves
// every restoring division and square root step.
// ----------------------------------------------------------------------------
module alr_sub_unit #(
   parameter int WIDTH = 19
) (
   input  logic [WIDTH-1:0] lhs,
   input  logic [WIDTH-1:0] rhs,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);
   logic [WIDTH:0] wide_diff;

   assign wide_diff = {1'b0, lhs} - {1'b0, rhs};
   assign diff      = wide_diff[WIDTH-1:0];
   assign ge        = ~wide_diff[WIDTH];
endmodule

/* rtl/alr_setup.sv */
// ----------------------------------------------------------------------------
// Line setup sequencer
// Computes the unit steps a = dx/len and b = dy/len in fixed point with a
// restoring division and a digit-by-digit square root on the shared unit.
// ----------------------------------------------------------------------------
module alr_setup #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [COORD_BITS-1:0] dx,
   input  logic [COORD_BITS-1:0] dy,
   output logic                  done,
   output logic [FRAC_BITS:0]    step_along,
   output logic [FRAC_BITS:0]    step_across
);
   import alr_pkg::*;

   localparam int SQ_W      = 2 * COORD_BITS;
   localparam int L2_W      = 2 * COORD_BITS + 1;
   localparam int REM_W     = 2 * COORD_BITS + 1;
   localparam int DT_W      = 2 * COORD_BITS + 2;
   localparam int Q_W       = 2 * FRAC_BITS + 1;
   localparam int V_W       = 2 * FRAC_BITS + 2;
   localparam int ROOT_W    = FRAC_BITS + 1;
   localparam int SR_W      = FRAC_BITS + 3;
   localparam int ST_W      = FRAC_BITS + 5;
   localparam int UW        = (DT_W > ST_W) ? DT_W : ST_W;
   localparam int DIV_LAST  = 2 * FRAC_BITS;
   localparam int SQRT_LAST = FRAC_BITS;
   localparam int CNT_W     = $clog2(2 * FRAC_BITS + 1);

   localparam logic [2:0] P_IDLE   = 3'd0;
   localparam logic [2:0] P_SQUARE = 3'd1;
   localparam logic [2:0] P_SUM    = 3'd2;
   localparam logic [2:0] P_DIV    = 3'd3;
   localparam logic [2:0] P_SQRT   = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [SQ_W-1:0]   sq_dx_ff, sq_dx_in;
   logic [SQ_W-1:0]   sq_dy_ff, sq_dy_in;
   logic [L2_W-1:0]   len2_ff, len2_in;
   logic              sel_ff, sel_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic              dvd_bit_ff, dvd_bit_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [V_W-1:0]    rad_ff, rad_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SR_W-1:0]   srem_ff, srem_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [ROOT_W-1:0] along_ff, along_in;
   logic [ROOT_W-1:0] across_ff, across_in;
   logic              done_ff, done_in;

   logic [DT_W-1:0]   div_trial;
   logic [ST_W-1:0]   sqrt_lhs;
   logic [ROOT_W+1:0] sqrt_rhs;
   logic [UW-1:0]     unit_lhs, unit_rhs, unit_diff;
   logic              unit_ge;
   logic [Q_W-1:0]    quo_next;
   logic [ROOT_W-1:0] root_next;

   assign div_trial = {rem_ff, dvd_bit_ff};
   assign sqrt_lhs  = {srem_ff, rad_ff[V_W-1:V_W-2]};
   assign sqrt_rhs  = {root_ff, 2'b01};
   assign unit_lhs  = (state_ff == P_DIV) ? UW'(div_trial) : UW'(sqrt_lhs);
   assign unit_rhs  = (state_ff == P_DIV) ? UW'(len2_ff) : UW'(sqrt_rhs);
   assign quo_next  = {quo_ff[Q_W-2:0], unit_ge};
   assign root_next = {root_ff[ROOT_W-2:0], unit_ge};

   alr_sub_unit #(.WIDTH(UW)) u_sub (
      .lhs  (unit_lhs),
      .rhs  (unit_rhs),
      .diff (unit_diff),
      .ge   (unit_ge)
   );

   always_comb begin
      state_in   = state_ff;
      sq_dx_in   = sq_dx_ff;
      sq_dy_in   = sq_dy_ff;
      len2_in    = len2_ff;
      sel_in     = sel_ff;
      rem_in     = rem_ff;
      dvd_bit_in = dvd_bit_ff;
      quo_in     = quo_ff;
      rad_in     = rad_ff;
      root_in    = root_ff;
      srem_in    = srem_ff;
      cnt_in     = cnt_ff;
      along_in   = along_ff;
      across_in  = across_ff;
      done_in    = 1'b0;
      case (state_ff)
         P_IDLE: begin
            if (start) begin
               if ((dx == '0) && (dy == '0)) begin
                  // zero length: no division, both steps zero
                  along_in  = '0;
                  across_in = '0;
                  done_in   = 1'b1;
               end else begin
                  state_in = P_SQUARE;
               end
            end
         end
         P_SQUARE: begin
            sq_dx_in = SQ_W'(dx) * SQ_W'(dx);
            sq_dy_in = SQ_W'(dy) * SQ_W'(dy);
            state_in = P_SUM;
         end
         P_SUM: begin
            len2_in = L2_W'(sq_dx_ff) + L2_W'(sq_dy_ff);
            sel_in  = 1'b0;
            // top bits of dx*dx << 2F already sit below len2
            rem_in     = REM_W'(sq_dx_ff >> 1);
            dvd_bit_in = sq_dx_ff[0];
            quo_in     = '0;
            cnt_in     = '0;
            state_in   = P_DIV;
         end
         P_DIV: begin
            rem_in     = unit_ge ? unit_diff[REM_W-1:0] : div_trial[REM_W-1:0];
            quo_in     = quo_next;
            dvd_bit_in = 1'b0;
            if (cnt_ff == CNT_W'(DIV_LAST)) begin
               rad_in   = V_W'(quo_next);
               srem_in  = '0;
               root_in  = '0;
               cnt_in   = '0;
               state_in = P_SQRT;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         P_SQRT: begin
            srem_in = unit_ge ? unit_diff[SR_W-1:0] : sqrt_lhs[SR_W-1:0];
            root_in = root_next;
            rad_in  = rad_ff << 2;
            if (cnt_ff == CNT_W'(SQRT_LAST)) begin
               cnt_in = '0;
               if (!sel_ff) begin
                  along_in   = root_next;
                  sel_in     = 1'b1;
                  rem_in     = REM_W'(sq_dy_ff >> 1);
                  dvd_bit_in = sq_dy_ff[0];
                  quo_in     = '0;
                  state_in   = P_DIV;
               end else begin
                  across_in = root_next;
                  done_in   = 1'b1;
                  state_in  = P_IDLE;
               end
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= P_IDLE;
         sel_ff   <= 1'b0;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_dx_ff   <= sq_dx_in;
      sq_dy_ff   <= sq_dy_in;
      len2_ff    <= len2_in;
      rem_ff     <= rem_in;
      dvd_bit_ff <= dvd_bit_in;
      quo_ff     <= quo_in;
      rad_ff     <= rad_in;
      root_ff    <= root_in;
      srem_ff    <= srem_in;
      along_ff   <= along_in;
      across_ff  <= across_in;
   end

   assign done        = done_ff;
   assign step_along  = along_ff;
   assign step_across = across_ff;
endmodule

/* rtl/alr_walker.sv */
// ----------------------------------------------------------------------------
// Pixel walker
// Steps the Bresenham decision variable and the fixed-point distance one
// pixel per transfer and holds each result in the output register.
// ----------------------------------------------------------------------------
module alr_walker #(
   parameter int COORD_BITS = 6,
   parameter int FRAC_BITS  = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  alr_pkg::alr_walk_ctl_type      ctl,
   output alr_pkg::alr_walk_stat_type     stat,
   input  logic [COORD_BITS-1:0]          x_start,
   input  logic [COORD_BITS-1:0]          y_start,
   input  logic [COORD_BITS-1:0]          x_end,
   input  logic [COORD_BITS-1:0]          y_end,
   input  logic [FRAC_BITS:0]             step_along,
   input  logic [FRAC_BITS:0]             step_across,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [alr_pkg::FIELD_W-1:0]    pixel_x,
   output logic [alr_pkg::FIELD_W-1:0]    pixel_y,
   output logic [alr_pkg::INTEN_W-1:0]    intensity,
   output logic                           last,
   output logic                           octant_error
);
   import alr_pkg::*;

   localparam int DIST_W = FRAC_BITS + 3;
   localparam int DEC_W  = COORD_BITS + 3;
   localparam int PROD_W = FRAC_BITS + 9;
   localparam logic [FRAC_BITS:0]  FIX_ONE  = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [PROD_W-1:0]   FIX_HALF = PROD_W'(FIX_ONE >> 1);

   logic                         busy_ff, busy_in;
   logic                         err_ff, err_in;
   logic [COORD_BITS-1:0]        x_ff, x_in;
   logic [COORD_BITS-1:0]        y_ff, y_in;
   logic signed [DEC_W-1:0]      dec_ff, dec_in;
   logic signed [DIST_W-1:0]     dist_ff, dist_in;
   logic                         vld_ff, vld_in;
   logic [FIELD_W-1:0]           px_ff, px_in;
   logic [FIELD_W-1:0]           py_ff, py_in;
   logic [INTEN_W-1:0]           int_ff, int_in;
   logic                         last_ff, last_in;
   logic                         oerr_ff, oerr_in;
   logic                         done_c;

   logic [COORD_BITS-1:0]        dx, dy;
   logic signed [DEC_W-1:0]      two_dy, two_dx, dec_init;
   logic signed [DIST_W-1:0]     a_s, b_s;
   logic [DIST_W-1:0]            mag;
   logic [FRAC_BITS:0]           cov;
   logic [PROD_W-1:0]            scaled;
   logic [INTEN_W-1:0]           inten;
   logic                         slot_free, emit, at_end, at_point;

   assign dx       = x_end - x_start;
   assign dy       = y_end - y_start;
   assign two_dy   = $signed({2'b00, dy, 1'b0});
   assign two_dx   = $signed({2'b00, dx, 1'b0});
   assign dec_init = two_dy - $signed({3'b000, dx});
   assign a_s      = $signed(DIST_W'(step_along));
   assign b_s      = $signed(DIST_W'(step_across));

   // coverage = clamp(1 - |d|), scaled by 255 and rounded half up
   assign mag    = dist_ff[DIST_W-1] ? DIST_W'(-dist_ff) : DIST_W'(dist_ff);
   assign cov    = (mag >= DIST_W'(FIX_ONE)) ? '0 : FIX_ONE - mag[FRAC_BITS:0];
   assign scaled = (PROD_W'(cov) << 8) - PROD_W'(cov) + FIX_HALF;
   assign inten  = scaled[FRAC_BITS+7:FRAC_BITS];

   assign slot_free = !vld_ff || rsp_ready;
   assign emit      = busy_ff && slot_free;
   assign at_end    = (x_ff == x_end);
   assign at_point  = ((x_ff == x_start) && (y_ff == y_start)) ||
                      ((x_ff == x_end) && (y_ff == y_end));

   always_comb begin
      busy_in = busy_ff;
      err_in  = err_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      dec_in  = dec_ff;
      dist_in = dist_ff;
      vld_in  = vld_ff && !rsp_ready;
      px_in   = px_ff;
      py_in   = py_ff;
      int_in  = int_ff;
      last_in = last_ff;
      oerr_in = oerr_ff;
      done_c  = 1'b0;
      if (ctl.start) begin
         busy_in = 1'b1;
         err_in  = ctl.oct_err;
         x_in    = x_start;
         y_in    = y_start;
         dec_in  = dec_init;
         dist_in = '0;
      end else if (emit) begin
         vld_in = 1'b1;
         if (err_ff) begin
            px_in   = '0;
            py_in   = '0;
            int_in  = '0;
            last_in = 1'b1;
            oerr_in = 1'b1;
            busy_in = 1'b0;
            done_c  = 1'b1;
         end else begin
            px_in   = FIELD_W'(x_ff);
            py_in   = FIELD_W'(y_ff);
            int_in  = at_point ? INTEN_FULL : inten;
            last_in = at_end;
            oerr_in = 1'b0;
            if (at_end) begin
               busy_in = 1'b0;
               done_c  = 1'b1;
            end else begin
               // advance x; advance y too on a diagonal step
               x_in = x_ff + COORD_BITS'(1);
               if (dec_ff[DEC_W-1]) begin
                  dec_in  = dec_ff + two_dy;
                  dist_in = dist_ff - b_s;
               end else begin
                  dec_in  = dec_ff + two_dy - two_dx;
                  dist_in = dist_ff + (a_s - b_s);
                  y_in    = y_ff + COORD_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         err_ff  <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         err_ff  <= err_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      dec_ff  <= dec_in;
      dist_ff <= dist_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      int_ff  <= int_in;
      last_ff <= last_in;
      oerr_ff <= oerr_in;
   end

   assign stat.busy    = busy_ff;
   assign stat.done    = done_c;
   assign rsp_valid    = vld_ff;
   assign pixel_x      = px_ff;
   assign pixel_y      = py_ff;
   assign intensity    = int_ff;
   assign last         = last_ff;
   assign octant_error = oerr_ff;
endmodule

/* rtl/antialiased_line_rasterizer_top.sv */
// ----------------------------------------------------------------------------
// Antialiased line rasterizer, top level
// Accepts one first-octant line command and emits one coverage result per
// pixel from the start column to the end column.
// ----------------------------------------------------------------------------
// Takes one line at a time. After the command transfer the setup sequencer
// forms the squared length and then uses one shared compare-subtract unit,
// which runs the restoring division and the square root for a and then for b.
// The walker then emits dx+1 pixels, one per cycle while the sink takes every
// transfer; the output register lets the next command transfer while the
// final pixel still waits. A single-point line skips the division and square
// root; a command outside the first octant gives one error result without
// running the setup sequencer.
// ----------------------------------------------------------------------------
`include "antialiased_line_rasterizer_top_defines.svh"

module antialiased_line_rasterizer_top #(
   parameter int COORD_BITS = alr_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = alr_pkg::FRAC_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   alr_req_if.sink    req_bus,
   alr_rsp_if.source  rsp_bus
);
   import alr_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SETUP = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;

   logic [1:0]            state_ff, state_in;
   logic [COORD_BITS-1:0] xs_ff, xs_in;
   logic [COORD_BITS-1:0] ys_ff, ys_in;
   logic [COORD_BITS-1:0] xe_ff, xe_in;
   logic [COORD_BITS-1:0] ye_ff, ye_in;
   logic                  oerr_ff, oerr_in;
   logic                  setup_go_ff, setup_go_in;
   logic                  walk_go_ff, walk_go_in;

   logic [COORD_BITS-1:0] in_xs, in_ys, in_xe, in_ye;
   logic                  accept, oct_bad;
   logic                  setup_done;
   logic [FRAC_BITS:0]    step_along, step_across;
   alr_walk_ctl_type      walk_ctl;
   alr_walk_stat_type     walk_stat;

   assign in_xs   = req_bus.x_start[COORD_BITS-1:0];
   assign in_ys   = req_bus.y_start[COORD_BITS-1:0];
   assign in_xe   = req_bus.x_end[COORD_BITS-1:0];
   assign in_ye   = req_bus.y_end[COORD_BITS-1:0];
   assign oct_bad = (in_xe < in_xs) || (in_ye < in_ys) ||
                    ((in_ye - in_ys) > (in_xe - in_xs));

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      state_in    = state_ff;
      xs_in       = xs_ff;
      ys_in       = ys_ff;
      xe_in       = xe_ff;
      ye_in       = ye_ff;
      oerr_in     = oerr_ff;
      setup_go_in = 1'b0;
      walk_go_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               xs_in   = in_xs;
               ys_in   = in_ys;
               xe_in   = in_xe;
               ye_in   = in_ye;
               oerr_in = oct_bad;
               // a rejected command needs no steps
               if (oct_bad) begin
                  walk_go_in = 1'b1;
                  state_in   = S_WALK;
               end else begin
                  setup_go_in = 1'b1;
                  state_in    = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            if (setup_done) begin
               walk_go_in = 1'b1;
               state_in   = S_WALK;
            end
         end
         S_WALK: begin
            if (walk_stat.done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         oerr_ff     <= 1'b0;
         setup_go_ff <= 1'b0;
         walk_go_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         oerr_ff     <= oerr_in;
         setup_go_ff <= setup_go_in;
         walk_go_ff  <= walk_go_in;
      end
   end

   always_ff @(posedge clock) begin
      xs_ff <= xs_in;
      ys_ff <= ys_in;
      xe_ff <= xe_in;
      ye_ff <= ye_in;
   end

   alr_setup #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_setup (
      .clock       (clock),
      .reset       (reset),
      .start       (setup_go_ff),
      .dx          (xe_ff - xs_ff),
      .dy          (ye_ff - ys_ff),
      .done        (setup_done),
      .step_along  (step_along),
      .step_across (step_across)
   );

   assign walk_ctl.start   = walk_go_ff;
   assign walk_ctl.oct_err = oerr_ff;

   alr_walker #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .ctl          (walk_ctl),
      .stat         (walk_stat),
      .x_start      (xs_ff),
      .y_start      (ys_ff),
      .x_end        (xe_ff),
      .y_end        (ye_ff),
      .step_along   (step_along),
      .step_across  (step_across),
      .rsp_ready    (rsp_bus.ready),
      .rsp_valid    (rsp_bus.valid),
      .pixel_x      (rsp_bus.pixel_x),
      .pixel_y      (rsp_bus.pixel_y),
      .intensity    (rsp_bus.intensity),
      .last         (rsp_bus.last),
      .octant_error (rsp_bus.octant_error)
   );

   `ALR_ASSERT(a_no_cmd_while_walking, accept |-> !walk_stat.busy, "command taken while walking")
   `ALR_ASSERT(a_setup_done_in_setup, setup_done |-> (state_ff == S_SETUP), "stray setup done")
   `ALR_ASSERT(a_walk_start_in_walk, walk_go_ff |-> (state_ff == S_WALK), "walk start outside walk")
   `ALR_ASSERT_NEVER(a_error_is_last, rsp_bus.valid && rsp_bus.octant_error && !rsp_bus.last,
                     "error result not marked last")
endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// Antialiased line rasterizer testbench
// Drives line commands through the request channel and checks every pixel
// against a local first-octant Bresenham walk with fixed-point distance
// tracking. The checks cover endpoints, octant rejects, output backpressure
// and random lines, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import alr_pkg::*;

   localparam int CLK_HALF    = 5;
   localparam int COORD_BITS  = COORD_BITS_DEF;
   localparam int FRAC_BITS   = FRAC_BITS_DEF;
   localparam int COORD_MASK  = (1 << COORD_BITS) - 1;
   localparam int FIELD_MAX   = (1 << FIELD_W) - 1;
   localparam longint FIX_ONE = longint'(1) << FRAC_BITS;
   localparam int IDLE_PCT    = 31;
   localparam int HOLD_CYCLES = 600;
   localparam int SETTLE      = 150;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [FIELD_W-1:0] x_start;
      logic [FIELD_W-1:0] y_start;
      logic [FIELD_W-1:0] x_end;
      logic [FIELD_W-1:0] y_end;
   } line_cmd_type;

   typedef struct packed {
      logic [FIELD_W-1:0] pixel_x;
      logic [FIELD_W-1:0] pixel_y;
      logic [INTEN_W-1:0] intensity;
      logic               last;
      logic               octant_error;
   } pixel_type;

   logic clock;
   logic reset;

   alr_req_if req_bus ();
   alr_rsp_if rsp_bus ();

   pixel_type awaited_pixels[$];
   bit        idle_on;
   int        rsp_hold_left;
   int        mismatch_count;
   int        line_count;
   int        reject_count;
   int        checked_count;
   int        cycle_count;

   antialiased_line_rasterizer_top #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial clock = 1'b0;
   always #CLK_HALF clock = ~clock;

   // ------------------------------------------------------------------
   // Line walk prediction
   // ------------------------------------------------------------------
   function automatic longint unsigned isqrt64(input longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v    -= root + probe;
            root  = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // part / sqrt(len2) in Q1.FRAC_BITS, floored
   function automatic longint unsigned unit_step(input longint unsigned part,
                                                 input longint unsigned len2);
      if (len2 == 0) return 0;
      return isqrt64(((part * part) << (2 * FRAC_BITS)) / len2);
   endfunction

   function automatic logic [INTEN_W-1:0] coverage_of(input longint offset);
      longint mag;
      longint cov;
      mag = (offset < 0) ? -offset : offset;
      cov = FIX_ONE - mag;
      if (cov < 0) cov = 0;
      if (cov > FIX_ONE) cov = FIX_ONE;
      return INTEN_W'((cov * 255 + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS);
   endfunction

   function automatic void rasterize_line(input line_cmd_type cmd);
      int unsigned     xs, ys, xe, ye, dx, dy, x, y;
      longint unsigned along, across;
      longint          offset;
      int              decision;
      pixel_type       px;
      xs = cmd.x_start & COORD_MASK;
      ys = cmd.y_start & COORD_MASK;
      xe = cmd.x_end & COORD_MASK;
      ye = cmd.y_end & COORD_MASK;
      if (xe < xs || ye < ys || (ye - ys) > (xe - xs)) begin
         px              = '0;
         px.last         = 1'b1;
         px.octant_error = 1'b1;
         awaited_pixels  = {awaited_pixels, px};
         reject_count++;
         return;
      end
      dx       = xe - xs;
      dy       = ye - ys;
      along    = unit_step(dx, dx * dx + dy * dy);
      across   = unit_step(dy, dx * dx + dy * dy);
      decision = 2 * int'(dy) - int'(dx);
      offset   = 0;
      x        = xs;
      y        = ys;
      while (1) begin
         px.pixel_x      = FIELD_W'(x);
         px.pixel_y      = FIELD_W'(y);
         px.intensity    = ((x == xs && y == ys) || (x == xe && y == ye)) ?
                           INTEN_FULL : coverage_of(offset);
         px.last         = (x == xe);
         px.octant_error = 1'b0;
         awaited_pixels  = {awaited_pixels, px};
         if (x == xe) break;
         if (decision < 0) begin
            decision += 2 * int'(dy);
            offset   -= longint'(across);
         end else begin
            decision += 2 * int'(dy) - 2 * int'(dx);
            offset   += longint'(along) - longint'(across);
            y         = (y + 1) & COORD_MASK;
         end
         x = (x + 1) & COORD_MASK;
      end
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      pixel_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (awaited_pixels.size() == 0) begin
            $error("unexpected result: x=%0d y=%0d intensity=%0d", rsp_bus.pixel_x,
                   rsp_bus.pixel_y, rsp_bus.intensity);
            mismatch_count++;
         end else begin
            want = awaited_pixels.pop_front();
            check_field("pixel_x", want.pixel_x, rsp_bus.pixel_x);
            check_field("pixel_y", want.pixel_y, rsp_bus.pixel_y);
            check_field("intensity", want.intensity, rsp_bus.intensity);
            check_field("last", want.last, rsp_bus.last);
            check_field("octant_error", want.octant_error, rsp_bus.octant_error);
            checked_count++;
         end
      end
   end

   // Result sink: random idling, plus a long hold-off when requested
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold_left--;
      end else begin
         rsp_bus.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
      end
   end

   // ------------------------------------------------------------------
   // Command side; every task below starts and ends on a falling edge
   // ------------------------------------------------------------------
   function automatic line_cmd_type line_of(input int xs, input int ys, input int xe,
                                            input int ye);
      line_cmd_type cmd;
      cmd.x_start = FIELD_W'(xs);
      cmd.y_start = FIELD_W'(ys);
      cmd.x_end   = FIELD_W'(xe);
      cmd.y_end   = FIELD_W'(ye);
      return cmd;
   endfunction

   // Leaves valid high; the caller drops it or offers the next line
   task automatic send_line(input line_cmd_type cmd);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.x_start <= cmd.x_start;
      req_bus.y_start <= cmd.y_start;
      req_bus.x_end   <= cmd.x_end;
      req_bus.y_end   <= cmd.y_end;
      do @(posedge clock); while (!req_bus.ready);
      rasterize_line(cmd);
      line_count++;
      @(negedge clock);
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      while (awaited_pixels.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic line_cmd_type random_line();
      int unsigned xs, dx, dy, ys;
      xs = $urandom_range(FIELD_MAX);
      dx = $urandom_range(FIELD_MAX - xs);
      dy = $urandom_range(dx);
      ys = $urandom_range(FIELD_MAX - dy);
      return line_of(xs, ys, xs + dx, ys + dy);
   endfunction

   function automatic line_cmd_type noise_line();
      return line_of($urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX),
                     $urandom_range(FIELD_MAX), $urandom_range(FIELD_MAX));
   endfunction

   function automatic line_cmd_type broken_line();
      int unsigned xs, ys, dx, dy;
      case ($urandom_range(2))
         0: begin
            xs = $urandom_range(FIELD_MAX, 1);
            return line_of(xs, $urandom_range(FIELD_MAX), $urandom_range(xs - 1),
                           $urandom_range(FIELD_MAX));
         end
         1: begin
            ys = $urandom_range(FIELD_MAX, 1);
            return line_of($urandom_range(FIELD_MAX), ys, $urandom_range(FIELD_MAX),
                           $urandom_range(ys - 1));
         end
         default: begin
            // rise steeper than the run
            xs = $urandom_range(FIELD_MAX - 1);
            dx = $urandom_range(FIELD_MAX - 1 - xs);
            dy = $urandom_range(FIELD_MAX, dx + 1);
            ys = $urandom_range(FIELD_MAX - dy);
            return line_of(xs, ys, xs + dx, ys + dy);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_edge_lines();
      send_line(line_of(0, 0, 0, 0));
      send_line(line_of(63, 63, 63, 63));
      send_line(line_of(21, 42, 21, 42));
      send_line(line_of(0, 0, 63, 0));
      send_line(line_of(0, 63, 63, 63));
      send_line(line_of(0, 0, 63, 63));
      send_line(line_of(5, 5, 6, 5));
      send_line(line_of(5, 5, 6, 6));
      send_line(line_of(62, 0, 63, 1));
      send_line(line_of(0, 0, 63, 31));
      send_line(line_of(3, 10, 40, 22));
      send_line(line_of(10, 20, 17, 21));
      send_line(line_of(0, 0, 2, 1));
   endtask

   task automatic test_octant_rejects();
      send_line(line_of(63, 0, 0, 0));
      send_line(line_of(0, 63, 63, 0));
      send_line(line_of(0, 0, 10, 20));
      send_line(line_of(0, 0, 0, 1));
      send_line(line_of(0, 0, 62, 63));
      send_line(line_of(20, 20, 19, 25));
   endtask

   // Stall the sink long enough that the command side backs up
   task automatic test_output_hold();
      rsp_hold_left = HOLD_CYCLES;
      send_line(line_of(0, 0, 40, 13));
      send_line(line_of(9, 30, 2, 30));
      send_line(line_of(33, 33, 33, 33));
      send_line(line_of(0, 10, 63, 50));
      send_line(line_of(7, 7, 9, 8));
      wait_drain();
   endtask

   // Let every line finish before the next command
   task automatic test_drained_lines();
      repeat (3) begin
         send_line(random_line());
         wait_drain();
      end
   endtask

   task automatic test_random_lines(input int count, input bit idling);
      int unsigned pick;
      idle_on = idling;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 70) send_line(random_line());
         else if (pick < 80) send_line(noise_line());
         else send_line(broken_line());
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      idle_on         = 1'b1;
      rsp_hold_left   = 0;
      mismatch_count  = 0;
      line_count      = 0;
      reject_count    = 0;
      checked_count   = 0;
      req_bus.valid   = 1'b0;
      req_bus.x_start = '0;
      req_bus.y_start = '0;
      req_bus.x_end   = '0;
      req_bus.y_end   = '0;
      rsp_bus.ready   = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_lines();
      test_octant_rejects();
      test_output_hold();
      test_drained_lines();
      test_random_lines(40, 1'b0);
      test_random_lines(90, 1'b1);

      wait_drain();
      repeat (SETTLE) @(posedge clock);
      if (awaited_pixels.size() != 0) begin
         $error("%0d expected results never arrived", awaited_pixels.size());
         mismatch_count += awaited_pixels.size();
      end
      $display("covered %0d line commands, %0d outside the first octant", line_count,
               reject_count);
      $display("checked %0d pixel results under idling and output backpressure",
               checked_count);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
   end

endmodule
